@@ rtl/lhp_pkg.sv @@
// Shared types, register codes and reset values for the latency histogram percentile block.
package lhp_pkg;

    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int NUM_LEVELS_DEF  = 5;
    localparam int MAX_LEVELS      = 5;
    localparam int QUEUE_DEPTH     = 2;

    localparam int COUNT_W = 32;
    localparam int FRAC_W  = 32;
    localparam int BWID_W  = 20;
    localparam int LAT_W   = 32;
    localparam int TOTAL_W = 48;
    localparam int LEVEL_W = 3;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;
    localparam int STAT_W  = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FRAC0 = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAC1 = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FRAC2 = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_FRAC3 = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_FRAC4 = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_BWIDTH = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_LIMIT = 3'd6;

    // Limit status codes
    localparam logic [STAT_W-1:0] LIMIT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] LIMIT_READ  = 2'd1;
    localparam logic [STAT_W-1:0] LIMIT_WRITE = 2'd2;

    // Level that carries the limit status
    localparam logic [LEVEL_W-1:0] LIMIT_LEVEL = 3'd1;

    typedef struct packed {
        logic [MAX_LEVELS-1:0][FRAC_W-1:0] frac;
        logic [BWID_W-1:0]                 bucket_width_ns;
        logic [LAT_W-1:0]                  latency_limit_ns;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        frac: {32'd429497, 32'd4294967, 32'd42949673, 32'd429496730, 32'd2147483648},
        bucket_width_ns: 20'd1000,
        latency_limit_ns: 32'hFFFF_FFFF
    };

    // One classified bucket on its way to the back end
    typedef struct packed {
        logic [COUNT_W-1:0] read_count;
        logic [COUNT_W-1:0] write_count;
        logic               last;
        logic               store;
    } entry_t;

endpackage

@@ rtl/lhp_front.sv @@
// Front end: accepts bucket requests and marks whether each one fits in the store.
module lhp_front #(
    parameter int NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lhp_pkg::COUNT_W-1:0]  read_count,
    input  logic [lhp_pkg::COUNT_W-1:0]  write_count,
    input  logic                         last_bucket,
    input  logic                         q_full,
    output logic                         q_push,
    output lhp_pkg::entry_t              q_entry
);
    import lhp_pkg::*;

    localparam int FILL_W = $clog2(NUM_BUCKETS + 1);

    logic [FILL_W-1:0] fill_reg;
    logic              fits;

    assign fits     = fill_reg < FILL_W'(NUM_BUCKETS);
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.read_count  = read_count;
        q_entry.write_count = write_count;
        q_entry.last        = last_bucket;
        q_entry.store       = fits;
    end

    // Count stored buckets; restart the count after the closing bucket of a histogram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (q_push)
        begin
            if (last_bucket)
            begin
                fill_reg <= '0;
            end
            else if (fits)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

endmodule

@@ rtl/lhp_fifo.sv @@
// Short queue of classified buckets between front and back end.
module lhp_fifo #(
    parameter int DEPTH = lhp_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lhp_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output lhp_pkg::entry_t rd_entry,
    output logic            not_empty
);
    import lhp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  rptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_entry  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/lhp_back.sv @@
// Back end: bucket store, totals, threshold sequencer, prefix-sum scan and result output.
module lhp_back #(
    parameter int NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_LEVELS  = lhp_pkg::NUM_LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lhp_pkg::entry_t              entry,
    input  logic                         entry_valid,
    output logic                         entry_pop,
    input  lhp_pkg::cfg_t                cfg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lhp_pkg::LEVEL_W-1:0]  level_index,
    output logic [lhp_pkg::LAT_W-1:0]    read_latency_ns,
    output logic [lhp_pkg::LAT_W-1:0]    write_latency_ns,
    output logic [lhp_pkg::STAT_W-1:0]   limit_status,
    output logic                         last_level
);
    import lhp_pkg::*;

    localparam int ADDR_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FILL_W  = $clog2(NUM_BUCKETS + 1);
    localparam int LVL_IW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int LIM_IDX = (NUM_LEVELS > 1) ? 1 : 0;
    localparam logic [LEVEL_W-1:0] LAST_LVL = LEVEL_W'(NUM_LEVELS - 1);
    localparam int HI_W    = TOTAL_W - COUNT_W;

    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;
    localparam logic [1:0] PH_SUB = 2'd3;

    typedef enum logic [1:0] {S_LOAD, S_THR, S_SCAN, S_OUT} state_t;

    state_t              state_reg;
    logic [FILL_W-1:0]   wptr_reg;
    logic [FILL_W-1:0]   rptr_reg;
    logic                rd_pend_reg;
    logic [TOTAL_W-1:0]  rtot_reg;
    logic [TOTAL_W-1:0]  wtot_reg;
    logic                side_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic [1:0]          phase_reg;
    logic [STAT_W-1:0]   status_reg;

    logic [2*COUNT_W-1:0] mult_reg;
    logic [COUNT_W-1:0]   plo_reg;
    logic [TOTAL_W-1:0]   prod_reg;
    logic [TOTAL_W-1:0]   thr_reg [2][NUM_LEVELS];
    logic [TOTAL_W-1:0]   cum_reg [2];
    logic [NUM_LEVELS-1:0] reached_reg [2];
    logic [LAT_W-1:0]     lat_reg [2][NUM_LEVELS];
    logic [LAT_W-1:0]     edge_ns_reg;

    logic [COUNT_W-1:0]   rd_mem [NUM_BUCKETS];
    logic [COUNT_W-1:0]   wr_mem [NUM_BUCKETS];
    logic [COUNT_W-1:0]   rdata_reg [2];

    logic [TOTAL_W-1:0]   rtot_eff;
    logic [TOTAL_W-1:0]   wtot_eff;
    logic [TOTAL_W-1:0]   tot_sel;
    logic [FRAC_W-1:0]    frac_sel;
    logic [COUNT_W-1:0]   mult_a;
    logic [2*COUNT_W-1:0] mult_p;
    logic [TOTAL_W-1:0]   cum_next [2];
    logic [NUM_LEVELS-1:0] hit [2];
    logic                 issue;
    logic                 scan_start;
    logic                 scan_done;
    logic [STAT_W-1:0]    status_next;

    assign entry_pop = (state_reg == S_LOAD) && entry_valid;

    // A zero total counts as one
    assign rtot_eff = (rtot_reg == '0) ? TOTAL_W'(1) : rtot_reg;
    assign wtot_eff = (wtot_reg == '0) ? TOTAL_W'(1) : wtot_reg;
    assign tot_sel  = side_reg ? wtot_eff : rtot_eff;
    assign frac_sel = cfg.frac[lvl_reg];

    // Shared multiplier: low half of the total first, then the high half
    assign mult_a = (phase_reg == PH_LO) ? tot_sel[COUNT_W-1:0]
                                         : {{(COUNT_W-HI_W){1'b0}}, tot_sel[TOTAL_W-1:COUNT_W]};
    assign mult_p = {{COUNT_W{1'b0}}, mult_a} * {{COUNT_W{1'b0}}, frac_sel};

    assign scan_start = (state_reg == S_THR) && (phase_reg == PH_SUB) && side_reg
                        && (lvl_reg == LAST_LVL);
    assign issue      = (state_reg == S_SCAN) && (rptr_reg < wptr_reg);
    assign scan_done  = (state_reg == S_SCAN) && (rptr_reg == wptr_reg) && !rd_pend_reg;

    // A level is reached only once every earlier level has been reached
    always_comb
    begin
        logic ok;
        for (int s = 0; s < 2; s++)
        begin
            cum_next[s] = cum_reg[s] + {{HI_W{1'b0}}, rdata_reg[s]};
            hit[s]      = '0;
            ok          = 1'b1;
            for (int j = 0; j < NUM_LEVELS; j++)
            begin
                if (!reached_reg[s][j])
                begin
                    if (ok && (cum_next[s] >= thr_reg[s][j]))
                    begin
                        hit[s][j] = 1'b1;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        priority if ((NUM_LEVELS > 1) && (lat_reg[0][LIM_IDX] > cfg.latency_limit_ns))
        begin
            status_next = LIMIT_READ;
        end
        else if ((NUM_LEVELS > 1) && (lat_reg[1][LIM_IDX] > cfg.latency_limit_ns))
        begin
            status_next = LIMIT_WRITE;
        end
        else
        begin
            status_next = LIMIT_OK;
        end
    end

    // Bucket stores
    always_ff @(posedge clk)
    begin
        if (entry_pop && entry.store)
        begin
            rd_mem[wptr_reg[ADDR_W-1:0]] <= entry.read_count;
            wr_mem[wptr_reg[ADDR_W-1:0]] <= entry.write_count;
        end
        if (issue)
        begin
            rdata_reg[0] <= rd_mem[rptr_reg[ADDR_W-1:0]];
            rdata_reg[1] <= wr_mem[rptr_reg[ADDR_W-1:0]];
        end
    end

    // Threshold and scan datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_THR)
        begin
            unique case (phase_reg)
                PH_LO:
                begin
                    mult_reg <= mult_p;
                end
                PH_HI:
                begin
                    plo_reg  <= mult_reg[2*COUNT_W-1:COUNT_W];
                    mult_reg <= mult_p;
                end
                PH_SUM:
                begin
                    prod_reg <= mult_reg[TOTAL_W-1:0] + {{HI_W{1'b0}}, plo_reg};
                end
                PH_SUB:
                begin
                    thr_reg[side_reg][lvl_reg[LVL_IW-1:0]] <= tot_sel - prod_reg;
                end
            endcase
        end
        if (scan_start)
        begin
            edge_ns_reg <= LAT_W'(cfg.bucket_width_ns);
            for (int s = 0; s < 2; s++)
            begin
                cum_reg[s]     <= '0;
                reached_reg[s] <= '0;
                for (int j = 0; j < NUM_LEVELS; j++)
                begin
                    lat_reg[s][j] <= '0;
                end
            end
        end
        else if ((state_reg == S_SCAN) && rd_pend_reg)
        begin
            edge_ns_reg <= edge_ns_reg + LAT_W'(cfg.bucket_width_ns);
            for (int s = 0; s < 2; s++)
            begin
                cum_reg[s]     <= cum_next[s];
                reached_reg[s] <= reached_reg[s] | hit[s];
                for (int j = 0; j < NUM_LEVELS; j++)
                begin
                    if (hit[s][j])
                    begin
                        lat_reg[s][j] <= edge_ns_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            rtot_reg    <= '0;
            wtot_reg    <= '0;
            side_reg    <= 1'b0;
            lvl_reg     <= '0;
            phase_reg   <= PH_LO;
            status_reg  <= LIMIT_OK;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (entry_pop)
                    begin
                        if (entry.store)
                        begin
                            wptr_reg <= wptr_reg + 1'b1;
                            rtot_reg <= rtot_reg + {{HI_W{1'b0}}, entry.read_count};
                            wtot_reg <= wtot_reg + {{HI_W{1'b0}}, entry.write_count};
                        end
                        if (entry.last)
                        begin
                            state_reg <= S_THR;
                            side_reg  <= 1'b0;
                            lvl_reg   <= '0;
                            phase_reg <= PH_LO;
                        end
                    end
                end
                S_THR:
                begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == PH_SUB)
                    begin
                        side_reg <= !side_reg;
                        if (side_reg)
                        begin
                            if (lvl_reg == LAST_LVL)
                            begin
                                state_reg   <= S_SCAN;
                                rptr_reg    <= '0;
                                rd_pend_reg <= 1'b0;
                            end
                            else
                            begin
                                lvl_reg <= lvl_reg + 1'b1;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_pend_reg <= issue;
                    if (issue)
                    begin
                        rptr_reg <= rptr_reg + 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg  <= S_OUT;
                        lvl_reg    <= '0;
                        status_reg <= status_next;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (lvl_reg == LAST_LVL)
                        begin
                            // Run complete: clear for the next histogram
                            state_reg <= S_LOAD;
                            lvl_reg   <= '0;
                            wptr_reg  <= '0;
                            rtot_reg  <= '0;
                            wtot_reg  <= '0;
                        end
                        else
                        begin
                            lvl_reg <= lvl_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign out_valid        = (state_reg == S_OUT);
    assign level_index      = lvl_reg;
    assign read_latency_ns  = lat_reg[0][lvl_reg[LVL_IW-1:0]];
    assign write_latency_ns = lat_reg[1][lvl_reg[LVL_IW-1:0]];
    assign limit_status     = (lvl_reg == LIMIT_LEVEL) ? status_reg : LIMIT_OK;
    assign last_level       = (lvl_reg == LAST_LVL);

endmodule

@@ rtl/latency_histogram_percentiles.sv @@
// Top level of the latency histogram percentile block: configuration registers and wiring.
//
// Usage: histogram buckets arrive on the input channel (in_valid/in_ready) in ascending
// order, each with a read count and a write count; last_bucket marks the final one.
// Buckets load at one per cycle while the back end is collecting; the two-entry queue
// behind the front end keeps accepting until full while the back end works on a finished
// histogram. After the last bucket the back end computes 2*NUM_LEVELS thresholds on one
// shared 32x32 multiplier, each through low-half product, high-half product, sum and
// subtract steps, then scans the stored buckets at one per cycle, then presents
// NUM_LEVELS results on the output channel (out_valid/out_ready), one per cycle while
// out_ready is high. A stalled receiver holds the current result; the queue then fills
// and in_ready drops. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while idle, as the block does not enforce this.
// Reset restores the default fractions, bucket width and limit, empties the queue and
// clears totals and fill counts; the bucket memories are not cleared.
module latency_histogram_percentiles #(
    parameter int NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_LEVELS  = lhp_pkg::NUM_LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lhp_pkg::COUNT_W-1:0]  read_count,
    input  logic [lhp_pkg::COUNT_W-1:0]  write_count,
    input  logic                         last_bucket,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lhp_pkg::LEVEL_W-1:0]  level_index,
    output logic [lhp_pkg::LAT_W-1:0]    read_latency_ns,
    output logic [lhp_pkg::LAT_W-1:0]    write_latency_ns,
    output logic [lhp_pkg::STAT_W-1:0]   limit_status,
    output logic                         last_level,
    input  logic                         cfg_we,
    input  logic [lhp_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [lhp_pkg::CDATA_W-1:0]  cfg_data
);
    import lhp_pkg::*;

    cfg_t   cfg_reg;
    entry_t push_entry;
    entry_t pop_entry;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAC0:  cfg_reg.frac[0] <= cfg_data;
                CFG_FRAC1:  cfg_reg.frac[1] <= cfg_data;
                CFG_FRAC2:  cfg_reg.frac[2] <= cfg_data;
                CFG_FRAC3:  cfg_reg.frac[3] <= cfg_data;
                CFG_FRAC4:  cfg_reg.frac[4] <= cfg_data;
                CFG_BWIDTH: cfg_reg.bucket_width_ns <= cfg_data[BWID_W-1:0];
                CFG_LIMIT:  cfg_reg.latency_limit_ns <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    lhp_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .read_count  (read_count),
        .write_count (write_count),
        .last_bucket (last_bucket),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    lhp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_entry  (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .rd_entry  (pop_entry),
        .not_empty (q_avail)
    );

    lhp_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .entry            (pop_entry),
        .entry_valid      (q_avail),
        .entry_pop        (q_pop),
        .cfg              (cfg_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .level_index      (level_index),
        .read_latency_ns  (read_latency_ns),
        .write_latency_ns (write_latency_ns),
        .limit_status     (limit_status),
        .last_level       (last_level)
    );

endmodule
